### src/lpmd_pkg.sv
// ----------------------------------------------------------------------------
// lpmd_pkg: shared types for the length-prefixed message deframer
// Parser phases, result kind codes and the result record that moves
// from the parser through the result queue to the output stage.
// ----------------------------------------------------------------------------
package lpmd_pkg;

	localparam logic [15:0] CAPACITY_AT_RESET = 16'd300;

	typedef enum logic [1:0] {
		PH_LEN_HI = 2'd0,
		PH_LEN_LO = 2'd1,
		PH_ID     = 2'd2,
		PH_BODY   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_ID   = 2'd0,
		KIND_DATA = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  value;
		logic [15:0] payload_length;
		logic        frame_last;
	} result_t;

	// parser -> queue
	typedef struct packed {
		logic    valid;
		result_t res;
	} push_t;

	// queue -> output stage
	typedef struct packed {
		logic    not_empty;
		result_t head;
	} head_t;

endpackage

### src/lpmd_front.sv
// ----------------------------------------------------------------------------
// lpmd_front: frame parser
// Tracks the frame phase per accepted byte, holds the capacity register
// and produces at most one result record per byte.
// ----------------------------------------------------------------------------
module lpmd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [15:0]      cfg_wr_data,
	input  logic             accept,
	input  logic [7:0]       rx_byte,
	output lpmd_pkg::push_t  push
);
	import lpmd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [15:0] left_q, left_d;
	logic        skip_q, skip_d;
	logic [15:0] max_len_q;
	logic [15:0] frame_len;
	logic [15:0] left_dec;
	logic [15:0] left_body;

	assign frame_len = {len_hi_q, rx_byte};
	assign left_dec  = left_q - 16'd1;
	// body bytes never count below zero
	assign left_body = (left_q != 16'd0) ? left_dec : left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= CAPACITY_AT_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEN_HI;
			len_hi_q <= '0;
			left_q   <= '0;
			skip_q   <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			len_hi_q <= len_hi_d;
			left_q   <= left_d;
			skip_q   <= skip_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		len_hi_d = len_hi_q;
		left_d   = left_q;
		skip_d   = skip_q;
		push     = '0;
		if (accept) begin
			unique case (phase_q)
				PH_LEN_HI: begin
					len_hi_d = rx_byte;
					phase_d  = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					if (frame_len == 16'd0) begin
						phase_d = PH_LEN_HI;
					end else begin
						left_d = frame_len;
						if (frame_len > max_len_q) begin
							skip_d                  = 1'b1;
							phase_d                 = PH_BODY;
							push.valid              = 1'b1;
							push.res.kind           = KIND_ERR;
							push.res.frame_last     = 1'b1;
						end else begin
							skip_d  = 1'b0;
							phase_d = PH_ID;
						end
					end
				end
				PH_ID: begin
					left_d                  = left_dec;
					phase_d                 = (left_dec == 16'd0) ? PH_LEN_HI : PH_BODY;
					push.valid              = 1'b1;
					push.res.kind           = KIND_ID;
					push.res.value          = rx_byte;
					push.res.payload_length = left_dec;
					push.res.frame_last     = (left_dec == 16'd0);
				end
				PH_BODY: begin
					left_d = left_body;
					if (left_body == 16'd0) begin
						phase_d = PH_LEN_HI;
					end
					if (skip_q) begin
						if (left_body == 16'd0) begin
							skip_d = 1'b0;
						end
					end else begin
						push.valid          = 1'b1;
						push.res.kind       = KIND_DATA;
						push.res.value      = rx_byte;
						push.res.frame_last = (left_body == 16'd0);
					end
				end
			endcase
		end
	end

endmodule

### src/lpmd_queue.sv
// ----------------------------------------------------------------------------
// lpmd_queue: result queue
// Small circular buffer between parser and output stage so either
// side can stall on its own.
// ----------------------------------------------------------------------------
module lpmd_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lpmd_pkg::push_t  push,
	input  logic             pop,
	output lpmd_pkg::head_t  head,
	output logic             full
);
	import lpmd_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	result_t        mem [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign do_push = push.valid && !full;
	assign do_pop  = pop && (count_q != '0);
	assign full    = (count_q == CW'(DEPTH));

	assign head.not_empty = (count_q != '0);
	assign head.head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count above depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push.valid)
		else $error("parser pushed into a full queue");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("pushed record not counted");

endmodule

### src/lpmd_back.sv
// ----------------------------------------------------------------------------
// lpmd_back: output stage
// Registers the queue head onto the result channel; refills whenever
// the register is empty or its record is taken.
// ----------------------------------------------------------------------------
module lpmd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  lpmd_pkg::head_t   head,
	output logic              pop,
	input  logic              out_stall,
	output logic              out_valid,
	output lpmd_pkg::result_t out_res
);
	import lpmd_pkg::*;

	logic    out_valid_q;
	result_t out_q;

	assign pop       = head.not_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= head.head;
		end
	end

endmodule

### src/length_prefixed_message_deframer_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_core: byte stream frame splitter
// Splits a byte stream into frames of a 16-bit big-endian length, an id
// byte and length-1 payload bytes; emits the id with its payload count,
// then each payload byte, marking the last result of each frame.
// Oversized frames give one error result and are skipped whole.
//
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+-----------------------------------
// input    | in        | in_valid / in_stall | rx_byte
// result   | out       | out_valid/out_stall | kind, value, payload_length,
//          |           |                     | frame_last
// config   | in        | cfg_wr_en           | cfg_wr_data (max_message_length)
//
// One byte per cycle sustained while the result queue is not full; the parser
// is combinational, so a result is written into the queue at its byte transfer
// edge and moves on to the output register once that register is free.
// in_stall rises only when the QUEUE_DEPTH-entry result queue is full, so
// a stalled result side backs up into the input after QUEUE_DEPTH + 1
// results (queue plus output register); in_stall falls the cycle after a
// record leaves the queue.
// Reset clears the parser phase, counters, queue and output valid; the
// capacity register returns to 300.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// results
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  value,
	output logic [15:0] payload_length,
	output logic        frame_last
);
	import lpmd_pkg::*;

	push_t   push;
	head_t   head;
	result_t out_res;
	logic    q_full;
	logic    pop;
	logic    in_xfer;

	// input transfer: parser state advances only here
	assign in_stall = q_full;
	assign in_xfer  = in_valid && !in_stall;

	lpmd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.accept      (in_xfer),
		.rx_byte     (rx_byte),
		.push        (push)
	);

	// decouples the parser from result-side stalls
	lpmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (q_full)
	);

	lpmd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign kind           = out_res.kind;
	assign value          = out_res.value;
	assign payload_length = out_res.payload_length;
	assign frame_last     = out_res.frame_last;

endmodule

### test/tb_length_prefixed_message_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_length_prefixed_message_deframer_core: self-checking bench
// Feeds framed byte streams into the deframer under several capacity
// settings and handshake pressure profiles, predicts every id, payload
// and oversize result, and checks the results in order, field by field.
// ----------------------------------------------------------------------------
module tb_length_prefixed_message_deframer_core;

	import lpmd_pkg::*;

	// Frame parser mirror plus the queue of results it predicts.
	class deframe_scoreboard;
		logic [15:0] capacity;
		phase_t      parse_phase;
		logic [7:0]  len_hi;
		logic [15:0] remaining;
		bit          discarding;
		result_t     expected_results[$];
		int unsigned errors;
		int unsigned bytes_in, ids_seen, data_seen, oversize_seen;

		function new();
			capacity      = CAPACITY_AT_RESET;
			parse_phase   = PH_LEN_HI;
			len_hi        = '0;
			remaining     = '0;
			discarding    = 0;
			errors        = 0;
			bytes_in      = 0;
			ids_seen      = 0;
			data_seen     = 0;
			oversize_seen = 0;
		endfunction

		function void push_result(kind_t k, logic [7:0] v, logic [15:0] plen, logic last);
			result_t r;
			r.kind           = k;
			r.value          = v;
			r.payload_length = plen;
			r.frame_last     = last;
			expected_results.push_back(r);
		endfunction

		function void note_byte(logic [7:0] b);
			logic [15:0] frame_len;
			bytes_in++;
			case (parse_phase)
				PH_LEN_HI: begin
					len_hi      = b;
					parse_phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					frame_len = {len_hi, b};
					if (frame_len == 0) begin
						parse_phase = PH_LEN_HI;
					end else begin
						remaining = frame_len;
						if (frame_len > capacity) begin
							discarding  = 1;
							parse_phase = PH_BODY;
							push_result(KIND_ERR, 8'h00, 16'h0000, 1'b1);
						end else begin
							discarding  = 0;
							parse_phase = PH_ID;
						end
					end
				end
				PH_ID: begin
					remaining   = remaining - 16'd1;
					parse_phase = (remaining == 0) ? PH_LEN_HI : PH_BODY;
					push_result(KIND_ID, b, remaining, remaining == 0);
				end
				default: begin
					if (remaining != 0)
						remaining = remaining - 16'd1;
					if (remaining == 0)
						parse_phase = PH_LEN_HI;
					if (discarding) begin
						if (remaining == 0)
							discarding = 0;
					end else begin
						push_result(KIND_DATA, b, 16'h0000, remaining == 0);
					end
				end
			endcase
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (expected_results.size() == 0) begin
				$error("unexpected result: kind %0d value %0d payload_length %0d frame_last %0d",
					got.kind, got.value, got.payload_length, got.frame_last);
				errors++;
				return;
			end
			exp = expected_results.pop_front();
			case (exp.kind)
				KIND_ID:   ids_seen++;
				KIND_DATA: data_seen++;
				default:   oversize_seen++;
			endcase
			if (got.kind !== exp.kind) begin
				$error("kind: expected %0d, got %0d", exp.kind, got.kind);
				errors++;
			end
			if (got.value !== exp.value) begin
				$error("value: expected %0d, got %0d", exp.value, got.value);
				errors++;
			end
			if (got.payload_length !== exp.payload_length) begin
				$error("payload_length: expected %0d, got %0d",
					exp.payload_length, got.payload_length);
				errors++;
			end
			if (got.frame_last !== exp.frame_last) begin
				$error("frame_last: expected %0d, got %0d", exp.frame_last, got.frame_last);
				errors++;
			end
		endfunction

		function int unsigned outstanding();
			return expected_results.size();
		endfunction
	endclass

	// Generous watchdog bound on the length of the run.
	localparam int unsigned CYCLE_LIMIT = 400000;
	// Results trail their byte through the queue and output register; settle before config writes.
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned HOLD_OFF_CYCLES = 300;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_wr_en = 0;
	logic [15:0] cfg_wr_data = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [1:0]  kind;
	logic [7:0]  value;
	logic [15:0] payload_length;
	logic        frame_last;

	deframe_scoreboard sb = new();

	// Bytes waiting to go out; a phase may stop in the middle of a frame,
	// so the remainder of that frame goes out in the next phase.
	logic [7:0]  stream_q[$];
	int unsigned in_idle_pct = 0;
	int unsigned out_stall_pct = 0;
	bit          hold_off_request = 0;
	int unsigned cycle_count = 0;

	length_prefixed_message_deframer_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.value          (value),
		.payload_length (payload_length),
		.frame_last     (frame_last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	initial begin
		forever @(posedge clk) begin
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Result side: check each transfer, then pick the next stall value.
	// A hold-off request from the main flow is counted down here so that
	// the stall stays up while the sender keeps offering bytes.
	initial begin
		result_t     got;
		int unsigned hold_left;
		hold_left = 0;
		forever @(posedge clk) begin
			if (out_valid && !out_stall) begin
				got.kind           = kind_t'(kind);
				got.value          = value;
				got.payload_length = payload_length;
				got.frame_last     = frame_last;
				sb.check_result(got);
			end
			if (hold_off_request) begin
				hold_left        = HOLD_OFF_CYCLES;
				hold_off_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < out_stall_pct);
			end
		end
	end

	// Append one frame: big-endian length, then that many bytes (id first).
	task automatic queue_frame(int unsigned frame_len);
		stream_q.push_back(frame_len[15:8]);
		stream_q.push_back(frame_len[7:0]);
		repeat (frame_len) stream_q.push_back(8'($urandom_range(0, 255)));
	endtask

	// Mostly short frames; a share lands right around the capacity so the
	// accept/skip boundary is hit from both sides.
	function automatic int unsigned next_frame_length();
		int unsigned r;
		int unsigned cap;
		r   = $urandom_range(0, 99);
		cap = sb.capacity;
		if (r < 8)
			return 0;
		if (r < 16)
			return 1;
		if (r < 65)
			return $urandom_range(2, 16);
		if (r < 85 && cap >= 1 && cap <= 400)
			return $urandom_range(cap - 1, cap + 1);
		return $urandom_range(17, 48);
	endfunction

	// One byte transfer, with random idle cycles ahead of it.
	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_byte(b);
	endtask

	// Send count bytes from the stream (count 0 drains the stream).
	task automatic send_stream(int unsigned count);
		int unsigned n;
		n = (count == 0) ? stream_q.size() : count;
		while (stream_q.size() < n) queue_frame(next_frame_length());
		repeat (n) send_byte(stream_q.pop_front());
		in_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [15:0] cap);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		sb.capacity = cap;
	endtask

	task automatic set_idling(int unsigned in_pct, int unsigned out_pct);
		in_idle_pct   = in_pct;
		out_stall_pct = out_pct;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset capacity of 300: empty frame, single-byte frames
		// with extreme ids, and a short frame with extreme payload bytes.
		stream_q = '{8'h00, 8'h00,
			8'h00, 8'h01, 8'hFF,
			8'h00, 8'h01, 8'h00,
			8'h00, 8'h03, 8'h00, 8'hFF, 8'h80};
		send_stream(0);

		// Directed, capacity 2: one frame just over (skipped) and one at it.
		write_capacity(16'd2);
		stream_q = '{8'h00, 8'h03, 8'h11, 8'h22, 8'h33,
			8'h00, 8'h02, 8'hAA, 8'h55};
		send_stream(0);

		// Directed, capacity zero: even a one-byte frame is oversized.
		write_capacity(16'd0);
		stream_q = '{8'h00, 8'h01, 8'h77};
		send_stream(0);

		// Random part, back at the reset capacity, no idling.
		write_capacity(CAPACITY_AT_RESET);
		set_idling(0, 0);
		send_stream(200);

		// Long receiver hold-off: the result queue fills and in_stall rises.
		wait_idle();
		hold_off_request = 1;
		send_stream(100);

		// Capacity zero: every new frame but an empty one is skipped.
		write_capacity(16'd0);
		set_idling(53, 0);
		send_stream(100);

		write_capacity(16'($urandom_range(1, 24)));
		set_idling(0, 53);
		send_stream(200);

		write_capacity(16'hFFFF);
		set_idling(30, 30);
		send_stream(200);

		write_capacity(16'd1);
		set_idling(53, 0);
		send_stream(100);

		write_capacity(16'($urandom_range(0, 65535)));
		set_idling(0, 53);
		send_stream(150);

		// Full capacity, no idling: finish the open frame plus one more.
		write_capacity(16'hFFFF);
		set_idling(0, 0);
		queue_frame(next_frame_length());
		send_stream(0);

		wait_idle();
		$display("tb: %0d bytes in, %0d ids, %0d payload bytes, %0d oversize drops checked",
			sb.bytes_in, sb.ids_seen, sb.data_seen, sb.oversize_seen);
		$display("tb: capacities 0, 1, 2, small, 300, random and 65535; idle and stall mixes");
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### sim.f
src/lpmd_pkg.sv
src/lpmd_front.sv
src/lpmd_queue.sv
src/lpmd_back.sv
src/length_prefixed_message_deframer_core.sv
test/tb_length_prefixed_message_deframer_core.sv
